// ----- sv/walat_pkg.sv -----
// Shared types, codes and constants of the write-ahead log admission table.
package walat_pkg;

    // Fixed field widths of the ports.
    localparam int CNT_W    = 6;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int BLOCK_W  = 32;

    // Defaults of the top-level parameters.
    localparam int DEF_LOG_ENTRIES = 32;
    localparam int DEF_BLOCK_BITS  = 32;

    // Reset value of the per-operation reserve register.
    localparam logic [CNT_W-1:0] RESERVE_RESET = 6'd10;

    // Largest value a count can hold.
    localparam logic [CNT_W-1:0] CNT_MAX = 6'h3F;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STS_ADMITTED  = 3'd0,
        STS_RETRY     = 3'd1,
        STS_APPENDED  = 3'd2,
        STS_ABSORBED  = 3'd3,
        STS_DROPPED   = 3'd4,
        STS_END_OPEN  = 3'd5,
        STS_COMMIT    = 3'd6,
        STS_UNDERFLOW = 3'd7
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_COMMIT
    } state_t;

endpackage

// ----- sv/walat_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module walat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/write_ahead_log_admission_table_unit.sv -----
// Write-ahead log admission table: begin/write/end sequencer over a block-number RAM.
//
// A command is taken when start is high and busy is low; busy stays high until the
// command is finished. Begin and end without a commit finish in the dispatch state.
// A write scans the N logged block numbers through the single read port of the log
// RAM, one entry per cycle, and finishes early when the block is found. An end that
// commits streams the N logged block numbers out on consecutive cycles. Every result
// is shown for one cycle with result_strobe high, and the receiver cannot stall it;
// the final result of a command has last set. The per-operation reserve is written
// through the cfg port while busy is low.
module write_ahead_log_admission_table_unit #(
    parameter int LOG_ENTRIES = walat_pkg::DEF_LOG_ENTRIES,
    parameter int BLOCK_BITS  = walat_pkg::DEF_BLOCK_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [walat_pkg::CMD_W-1:0]     cmd,
    input  logic [walat_pkg::BLOCK_W-1:0]   block_number,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [walat_pkg::CNT_W-1:0]     cfg_data,
    output logic                            result_strobe,
    output logic [walat_pkg::STATUS_W-1:0]  status,
    output logic [walat_pkg::BLOCK_W-1:0]   committed_block,
    output logic [walat_pkg::CNT_W-1:0]     entry_count,
    output logic [walat_pkg::CNT_W-1:0]     open_count,
    output logic                            last
);

    import walat_pkg::*;

    localparam int AW = $clog2(LOG_ENTRIES);
    localparam int NEED_W = 2 * CNT_W + 2;
    localparam logic [CNT_W:0]    LOG_N    = (CNT_W+1)'(LOG_ENTRIES);
    localparam logic [NEED_W-1:0] LOG_NEED = NEED_W'(LOG_ENTRIES);

    // Sequencer and table state.
    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [BLOCK_BITS-1:0] blk_reg, blk_next;
    logic [CNT_W-1:0]      reserve_reg, reserve_next;
    logic [CNT_W-1:0]      entries_reg, entries_next;
    logic [CNT_W-1:0]      open_reg, open_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  rd_last_reg, rd_last_next;

    // Result registers.
    logic                  strobe_reg, strobe_next;
    status_t               status_reg, status_next;
    logic [BLOCK_BITS-1:0] blk_out_reg, blk_out_next;
    logic [CNT_W-1:0]      ec_out_reg, ec_out_next;
    logic [CNT_W-1:0]      oc_out_reg, oc_out_next;
    logic                  last_reg, last_next;

    // Log RAM ports.
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [BLOCK_BITS-1:0] rd_data;

    // Shared compare and arithmetic terms.
    logic                  accept;
    logic                  issue;
    logic                  hit;
    logic [NEED_W-1:0]     need;
    logic                  begin_ok;
    logic [CNT_W:0]        limit_raw;
    logic [CNT_W:0]        limit;
    logic                  may_append;

    walat_ram #(
        .WIDTH (BLOCK_BITS),
        .DEPTH (LOG_ENTRIES)
    ) u_log_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (blk_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept = start && (state_reg == S_IDLE);

    // Scan and commit walk the table while the index is below the entry count.
    assign issue = idx_reg < entries_reg;
    assign hit   = rd_pend_reg && (rd_data == blk_reg);

    // Admission check: entries plus a reserve for every open operation and the new one.
    assign need = NEED_W'(entries_reg)
                + NEED_W'((NEED_W'(open_reg) + NEED_W'(1)) * NEED_W'(reserve_reg));
    assign begin_ok = (open_reg != CNT_MAX) && (need <= LOG_NEED);

    // Append limit is the log size minus the reserve, floored at zero and capped.
    assign limit_raw = ((CNT_W+1)'(reserve_reg) >= LOG_N) ? '0
                     : LOG_N - (CNT_W+1)'(reserve_reg);
    assign limit = (limit_raw > (CNT_W+1)'(CNT_MAX)) ? (CNT_W+1)'(CNT_MAX) : limit_raw;
    assign may_append = (CNT_W+1)'(entries_reg) < limit;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    state_next = S_SCAN;
                end
                else if ((cmd_reg == CMD_END) && (open_reg == CNT_W'(1))
                         && (entries_reg != '0))
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (hit || !issue)
                begin
                    state_next = S_IDLE;
                end
            end
            S_COMMIT:
            begin
                if (!issue && !rd_pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result logic.
    always_comb
    begin
        cmd_next     = cmd_reg;
        blk_next     = blk_reg;
        reserve_next = reserve_reg;
        entries_next = entries_reg;
        open_next    = open_reg;
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        rd_last_next = rd_last_reg;
        strobe_next  = 1'b0;
        status_next  = status_reg;
        blk_out_next = blk_out_reg;
        ec_out_next  = ec_out_reg;
        oc_out_next  = oc_out_reg;
        last_next    = last_reg;
        wr_en        = 1'b0;
        wr_addr      = entries_reg[AW-1:0];
        rd_en        = 1'b0;
        rd_addr      = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    reserve_next = cfg_data;
                end
                if (accept)
                begin
                    cmd_next = cmd;
                    blk_next = block_number[BLOCK_BITS-1:0];
                    idx_next = '0;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_BEGIN:
                    begin
                        strobe_next  = 1'b1;
                        blk_out_next = '0;
                        ec_out_next  = entries_reg;
                        last_next    = 1'b1;
                        if (begin_ok)
                        begin
                            open_next   = open_reg + CNT_W'(1);
                            status_next = STS_ADMITTED;
                            oc_out_next = open_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STS_RETRY;
                            oc_out_next = open_reg;
                        end
                    end
                    CMD_END:
                    begin
                        blk_out_next = '0;
                        last_next    = 1'b1;
                        if (open_reg == '0)
                        begin
                            strobe_next = 1'b1;
                            status_next = STS_UNDERFLOW;
                            ec_out_next = entries_reg;
                            oc_out_next = '0;
                        end
                        else if (open_reg != CNT_W'(1))
                        begin
                            strobe_next = 1'b1;
                            open_next   = open_reg - CNT_W'(1);
                            status_next = STS_END_OPEN;
                            ec_out_next = entries_reg;
                            oc_out_next = open_reg - CNT_W'(1);
                        end
                        else
                        begin
                            open_next = '0;
                            if (entries_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = STS_UNDERFLOW;
                                ec_out_next = '0;
                                oc_out_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        // Write starts its scan in the next state; other codes do nothing.
                    end
                endcase
            end
            S_SCAN:
            begin
                blk_out_next = blk_reg;
                oc_out_next  = open_reg;
                last_next    = 1'b1;
                if (hit)
                begin
                    strobe_next = 1'b1;
                    status_next = STS_ABSORBED;
                    ec_out_next = entries_reg;
                end
                else if (issue)
                begin
                    rd_en        = 1'b1;
                    idx_next     = idx_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                else if (may_append)
                begin
                    wr_en        = 1'b1;
                    entries_next = entries_reg + CNT_W'(1);
                    strobe_next  = 1'b1;
                    status_next  = STS_APPENDED;
                    ec_out_next  = entries_reg + CNT_W'(1);
                end
                else
                begin
                    strobe_next = 1'b1;
                    status_next = STS_DROPPED;
                    ec_out_next = entries_reg;
                end
            end
            S_COMMIT:
            begin
                // Present the entry read in the previous cycle.
                if (rd_pend_reg)
                begin
                    strobe_next  = 1'b1;
                    status_next  = STS_COMMIT;
                    blk_out_next = rd_data;
                    ec_out_next  = '0;
                    oc_out_next  = '0;
                    last_next    = rd_last_reg;
                end
                if (issue)
                begin
                    rd_en        = 1'b1;
                    idx_next     = idx_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                    rd_last_next = (idx_reg + CNT_W'(1)) == entries_reg;
                end
                else if (!rd_pend_reg)
                begin
                    entries_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            reserve_reg <= RESERVE_RESET;
            entries_reg <= '0;
            open_reg    <= '0;
            rd_pend_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            reserve_reg <= reserve_next;
            entries_reg <= entries_next;
            open_reg    <= open_next;
            rd_pend_reg <= rd_pend_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        blk_reg     <= blk_next;
        idx_reg     <= idx_next;
        rd_last_reg <= rd_last_next;
        status_reg  <= status_next;
        blk_out_reg <= blk_out_next;
        ec_out_reg  <= ec_out_next;
        oc_out_reg  <= oc_out_next;
        last_reg    <= last_next;
    end

    // Port drive.
    assign busy            = (state_reg != S_IDLE);
    assign cfg_ready       = (state_reg == S_IDLE);
    assign result_strobe   = strobe_reg;
    assign status          = status_reg;
    assign committed_block = BLOCK_W'(blk_out_reg);
    assign entry_count     = ec_out_reg;
    assign open_count      = oc_out_reg;
    assign last            = last_reg;

`ifndef NO_ASSERTIONS
    // A result only follows a cycle in which a command was being worked on.
    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result strobe without a command in progress");

    // A commit run delivers its entries on consecutive cycles.
    a_commit_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |=> result_strobe)
        else $error("gap inside a multi-result run");

    // The entry count never passes the log size.
    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W+1)'(entries_reg) <= LOG_N)
        else $error("entry count beyond log size");

    // The table walk never runs past the logged entries.
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) || (state_reg == S_COMMIT)) |-> (idx_reg <= entries_reg))
        else $error("scan index beyond entry count");

    // An accepted command makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
`endif

endmodule
